[rtl/ntx_pkg.sv]
// ----------------------------------------------------------------------------
// ntx_pkg: shared types and constants for the neighbor table
// Action codes, status codes and the word types of both channels.
// ----------------------------------------------------------------------------
package ntx_pkg;

    localparam int unsigned DEPTH_DEF    = 64;
    localparam int unsigned QUEUE_DEPTH  = 2;
    localparam logic [15:0] LIFETIME_RST = 16'd15;

    typedef enum logic [2:0] {
        ACT_FIND    = 3'd0,
        ACT_INSERT  = 3'd1,
        ACT_REMOVE  = 3'd2,
        ACT_REFRESH = 3'd3,
        ACT_TICK    = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_ABSENT  = 2'd1,
        ST_PRESENT = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // what the front end passes to the back end
    typedef enum logic [1:0] {
        OP_NONE,
        OP_LOOKUP,
        OP_TICK
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] neighbor_address;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] remaining_ticks;
        logic [6:0]  entry_count;
    } out_word_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  action;
        logic [31:0] addr;
    } cmd_t;

endpackage

[rtl/ntx_front.sv]
// ----------------------------------------------------------------------------
// ntx_front: input stage and command queue
// Classifies each input word and holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
module ntx_front #(
    parameter int unsigned QDEPTH = ntx_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ntx_pkg::in_word_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ntx_pkg::cmd_t     cmd
);
    import ntx_pkg::*;

    localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    cmd_t             q_reg [QDEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      cnt_reg, cnt_next;
    cmd_t             cls;
    logic             push, pop;

    always_comb begin
        cls.action = s_data.action;
        cls.addr   = s_data.neighbor_address;
        case (s_data.action)
            ACT_FIND, ACT_INSERT, ACT_REMOVE, ACT_REFRESH: cls.op = OP_LOOKUP;
            ACT_TICK: cls.op = OP_TICK;
            default:  cls.op = OP_NONE;
        endcase
    end

    assign s_ready   = cnt_reg < (PW+1)'(QDEPTH);
    assign cmd_valid = cnt_reg != '0;
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

[rtl/ntx_back.sv]
// ----------------------------------------------------------------------------
// ntx_back: table engine
// Walks the slot memories one slot per cycle, then applies the action.
// ----------------------------------------------------------------------------
module ntx_back #(
    parameter int unsigned DEPTH = ntx_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [15:0]        lifetime,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  ntx_pkg::cmd_t      cmd,
    output logic               m_valid,
    input  logic               m_ready,
    output ntx_pkg::out_word_t m_data
);
    import ntx_pkg::*;

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // address and lifetime memories; valid bits in flops
    logic [31:0]      addr_mem [DEPTH];
    logic [15:0]      life_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg, valid_next;

    state_t           state_reg, state_next;
    cmd_t             cur_reg, cur_next;
    logic [IW:0]      idx_reg, idx_next;     // read address issued
    logic [IW-1:0]    ridx_reg;              // slot whose data is in rd_*
    logic             rd_vld_reg;
    logic [31:0]      rd_addr_reg;
    logic [15:0]      rd_life_reg;
    logic             hit_reg, hit_next;
    logic [IW-1:0]    hit_idx_reg, hit_idx_next;
    logic [15:0]      hit_life_reg, hit_life_next;
    logic             free_reg, free_next;
    logic [IW-1:0]    free_idx_reg, free_idx_next;
    logic [CW-1:0]    count_reg, count_next;
    out_word_t        out_reg, out_next;
    logic             out_vld_reg, out_vld_next;

    logic             wr_en;
    logic [IW-1:0]    wr_idx;
    logic             wr_addr_en;
    logic [15:0]      wr_life;
    logic [15:0]      fresh;
    logic             rd_pending, rd_pending_reg;
    logic             slot_v;

    assign fresh     = (lifetime == 16'd0) ? 16'd1 : lifetime;
    assign m_valid   = out_vld_reg;
    assign m_data    = out_reg;
    assign slot_v    = valid_reg[ridx_reg];
    assign rd_pending = (state_reg == S_SCAN) && (idx_reg < (IW+1)'(DEPTH));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && !out_vld_reg) begin
                    state_next = (cmd.op == OP_NONE) ? S_RESULT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!rd_pending && !rd_pending_reg) begin
                    state_next = (cur_reg.op == OP_TICK) ? S_RESULT : S_ACT;
                end
            end
            S_ACT:    state_next = S_RESULT;
            S_RESULT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd_ready     = (state_reg == S_IDLE) && !out_vld_reg;
        cur_next      = cur_reg;
        idx_next      = idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_life_next = hit_life_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        valid_next    = valid_reg;
        count_next    = count_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        wr_en         = 1'b0;
        wr_idx        = ridx_reg;
        wr_addr_en    = 1'b0;
        wr_life       = fresh;
        case (state_reg)
            S_IDLE: begin
                if (cmd_valid && !out_vld_reg) begin
                    cur_next  = cmd;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (rd_pending) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_pending_reg) begin
                    if (cur_reg.op == OP_TICK) begin
                        if (slot_v) begin
                            if (rd_life_reg <= 16'd1) begin
                                valid_next[ridx_reg] = 1'b0;
                                count_next = count_next - 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                wr_life = rd_life_reg - 16'd1;
                            end
                        end
                    end else begin
                        if (slot_v && rd_addr_reg == cur_reg.addr && !hit_reg) begin
                            hit_next      = 1'b1;
                            hit_idx_next  = ridx_reg;
                            hit_life_next = rd_life_reg;
                        end
                        if (!slot_v && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = ridx_reg;
                        end
                    end
                end
            end
            S_ACT: begin
                wr_idx = hit_idx_reg;
                case (cur_reg.action)
                    ACT_INSERT: begin
                        if (!hit_reg && free_reg) begin
                            wr_en      = 1'b1;
                            wr_addr_en = 1'b1;
                            wr_idx     = free_idx_reg;
                            valid_next[free_idx_reg] = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    ACT_REMOVE: begin
                        if (hit_reg) begin
                            valid_next[hit_idx_reg] = 1'b0;
                            count_next = count_reg - 1'b1;
                        end
                    end
                    ACT_REFRESH: begin
                        wr_en = hit_reg;
                    end
                    default: ;
                endcase
            end
            S_RESULT: begin
                out_vld_next           = 1'b1;
                out_next.status        = ST_DONE;
                out_next.remaining_ticks = 16'd0;
                out_next.entry_count   = 7'(count_reg);
                if (cur_reg.op == OP_LOOKUP) begin
                    case (cur_reg.action)
                        ACT_FIND: begin
                            if (hit_reg) out_next.remaining_ticks = hit_life_reg;
                            else         out_next.status = ST_ABSENT;
                        end
                        ACT_INSERT: begin
                            if (hit_reg)       out_next.status = ST_PRESENT;
                            else if (!free_reg) out_next.status = ST_FULL;
                        end
                        ACT_REMOVE, ACT_REFRESH: begin
                            if (!hit_reg) out_next.status = ST_ABSENT;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            count_reg      <= '0;
            out_vld_reg    <= 1'b0;
            rd_pending_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            count_reg      <= count_next;
            out_vld_reg    <= out_vld_next;
            rd_pending_reg <= rd_pending;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        hit_life_reg <= hit_life_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        out_reg      <= out_next;
        ridx_reg     <= idx_reg[IW-1:0];
    end

    // memories: one read and one write per cycle
    always_ff @(posedge aclk) begin
        rd_addr_reg <= addr_mem[idx_reg[IW-1:0]];
        rd_life_reg <= life_mem[idx_reg[IW-1:0]];
        if (wr_en) begin
            life_mem[wr_idx] <= wr_life;
        end
        if (wr_addr_en) begin
            addr_mem[wr_idx] <= cur_reg.addr;
        end
    end

endmodule

[rtl/neighbor_table_with_expiry.sv]
// ----------------------------------------------------------------------------
// neighbor_table_with_expiry: aging address table
// Find, insert, remove, refresh and tick over a table of aged addresses.
// ----------------------------------------------------------------------------
// channel | ports          | word
// input   | s_valid/ready  | action, neighbor_address
// result  | m_valid/ready  | status, remaining_ticks, entry_count
// config  | cfg_valid/ready| entry_lifetime
//
// The back end reads one slot a cycle from the address and lifetime memories
// for find, insert, remove and refresh, then applies the action; a tick ages
// each slot as it is read instead. Unused action codes skip the read. Reset
// is synchronous; no clearing pass.
// A stalled result holds the back end; the front queue takes up to two more
// words, then drops s_ready.
module neighbor_table_with_expiry #(
    parameter int unsigned TABLE_DEPTH = ntx_pkg::DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ntx_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ntx_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);
    import ntx_pkg::*;

    logic [15:0] lifetime_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lifetime_reg <= LIFETIME_RST;
        end else if (cfg_valid) begin
            lifetime_reg <= cfg_data;
        end
    end

    ntx_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ntx_back #(.DEPTH(TABLE_DEPTH)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .lifetime  (lifetime_reg),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

[rtl/ntx_checker.sv]
// ----------------------------------------------------------------------------
// ntx_checker: port-level checks
// Watches the top level's ports and flags result channel slips.
// ----------------------------------------------------------------------------
module ntx_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input ntx_pkg::out_word_t m_data
);
    import ntx_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !$isunknown(m_data))
        else $error("unknown bits in result word");

    a_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_DONE |-> m_data.remaining_ticks == 16'd0)
        else $error("ticks on failed action");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_ctl: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown({s_ready, m_valid}))
        else $error("unknown handshake");

endmodule

bind neighbor_table_with_expiry ntx_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[sim/neighbor_table_with_expiry_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// neighbor_table_with_expiry_tb: self-checking bench for the aging table
// Drives actions through a directed table, then random traffic biased toward a
// small address pool so hits, fills and expiries all occur. Every result word
// is compared with a behavioral copy of the table held in the bench.
// ----------------------------------------------------------------------------
module neighbor_table_with_expiry_tb;
    import ntx_pkg::*;

    localparam int DEPTH = 64;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_word_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_word_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [15:0] cfg_data = '0;

    neighbor_table_with_expiry #(.TABLE_DEPTH(DEPTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #10 aclk = ~aclk;

    // bench copy of the table
    logic [15:0] tbl_lifetime_reg;
    logic        tbl_valid [DEPTH];
    logic [31:0] tbl_addr [DEPTH];
    logic [15:0] tbl_left [DEPTH];
    int          tbl_count;

    out_word_t   pending_words[$];
    int          errors = 0;

    typedef struct {
        action_t     act;
        logic [31:0] addr;
        bit          known;
        out_word_t   word;
    } row_t;

    function automatic logic [15:0] fresh_life();
        return (tbl_lifetime_reg == 16'd0) ? 16'd1 : tbl_lifetime_reg;
    endfunction

    function automatic int find_slot(logic [31:0] a);
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i] && tbl_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic out_word_t apply_action(in_word_t w);
        out_word_t r;
        int hit;
        r = '0;
        r.status = ST_DONE;
        hit = find_slot(w.neighbor_address);
        case (w.action)
            ACT_FIND: begin
                if (hit < 0) r.status = ST_ABSENT;
                else r.remaining_ticks = tbl_left[hit];
            end
            ACT_INSERT: begin
                if (hit >= 0) r.status = ST_PRESENT;
                else if (tbl_count >= DEPTH) r.status = ST_FULL;
                else begin
                    for (int i = 0; i < DEPTH; i++)
                        if (!tbl_valid[i]) begin
                            tbl_valid[i] = 1'b1;
                            tbl_addr[i] = w.neighbor_address;
                            tbl_left[i] = fresh_life();
                            tbl_count++;
                            break;
                        end
                end
            end
            ACT_REMOVE: begin
                if (hit < 0) r.status = ST_ABSENT;
                else begin
                    tbl_valid[hit] = 1'b0;
                    tbl_count--;
                end
            end
            ACT_REFRESH: begin
                if (hit < 0) r.status = ST_ABSENT;
                else tbl_left[hit] = fresh_life();
            end
            ACT_TICK: begin
                for (int i = 0; i < DEPTH; i++)
                    if (tbl_valid[i]) begin
                        if (tbl_left[i] <= 16'd1) begin
                            tbl_left[i] = 16'd0;
                            tbl_valid[i] = 1'b0;
                            tbl_count--;
                        end else tbl_left[i] = tbl_left[i] - 16'd1;
                    end
            end
            default: ;
        endcase
        r.entry_count = tbl_count[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    // s_valid stays high into the next word only when no idle cycles follow
    task automatic send_word(in_word_t w, bit known, out_word_t typed);
        out_word_t e;
        int gap;
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        e = apply_action(w);
        if (known && e != typed) report_mismatch("directed table row", e, typed);
        pending_words.push_back(e);
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic stop_input();
        s_valid <= 1'b0;
    endtask

    task automatic write_lifetime(logic [15:0] v);
        stop_input();
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DEPTH + 8) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_lifetime_reg = v;
    endtask

    // result side
    int stall_left = 0;
    int ready_draw;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("unexpected word", m_data, 0);
                end else begin
                    out_word_t e;
                    e = pending_words.pop_front();
                    if (m_data.status != e.status)
                        report_mismatch("status", m_data.status, e.status);
                    if (m_data.remaining_ticks != e.remaining_ticks)
                        report_mismatch("remaining_ticks", m_data.remaining_ticks,
                                        e.remaining_ticks);
                    if (m_data.entry_count != e.entry_count)
                        report_mismatch("entry_count", m_data.entry_count,
                                        e.entry_count);
                end
                ready_draw = $urandom_range(0, 3);
                stall_left <= ready_draw;
                m_ready <= (ready_draw == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= (stall_left == 1);
            end else m_ready <= 1'b1;
        end
    end

    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom_range(0, 79))};
            default: return 32'($urandom_range(0, 79));
        endcase
    endfunction

    function automatic action_t pick_act(int phase);
        int r;
        r = $urandom_range(0, 99);
        if (phase == 1) begin
            // fill phase: mostly inserts to reach a full table
            if (r < 70) return ACT_INSERT;
        end
        if (r < 20) return ACT_FIND;
        if (r < 45) return ACT_INSERT;
        if (r < 58) return ACT_REMOVE;
        if (r < 72) return ACT_REFRESH;
        if (r < 98) return ACT_TICK;
        return action_t'(3'($urandom_range(5, 7)));
    endfunction

    initial begin
        row_t rows[$];
        in_word_t w;
        out_word_t z;
        logic [15:0] lifes[6];
        lifes = '{16'd3, 16'd65535, 16'd0, 16'd1, 16'd200, 16'd7};
        tbl_lifetime_reg = LIFETIME_RST;
        for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 1'b0;
        tbl_count = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows: typed words where obvious, else predicted
        z = '0;
        rows.push_back('{ACT_FIND, 32'h0, 1, '{ST_ABSENT, 16'd0, 7'd0}});
        rows.push_back('{ACT_REMOVE, 32'hFFFFFFFF, 1, '{ST_ABSENT, 16'd0, 7'd0}});
        rows.push_back('{ACT_REFRESH, 32'h0, 1, '{ST_ABSENT, 16'd0, 7'd0}});
        rows.push_back('{ACT_TICK, 32'hFFFFFFFF, 1, '{ST_DONE, 16'd0, 7'd0}});
        rows.push_back('{ACT_INSERT, 32'h0, 1, '{ST_DONE, 16'd0, 7'd1}});
        rows.push_back('{ACT_INSERT, 32'hFFFFFFFF, 1, '{ST_DONE, 16'd0, 7'd2}});
        rows.push_back('{ACT_INSERT, 32'h0, 1, '{ST_PRESENT, 16'd0, 7'd2}});
        rows.push_back('{ACT_FIND, 32'hFFFFFFFF, 1, '{ST_DONE, 16'd15, 7'd2}});
        rows.push_back('{ACT_TICK, 32'h0, 1, '{ST_DONE, 16'd0, 7'd2}});
        rows.push_back('{ACT_FIND, 32'h0, 1, '{ST_DONE, 16'd14, 7'd2}});
        rows.push_back('{ACT_REFRESH, 32'h0, 1, '{ST_DONE, 16'd0, 7'd2}});
        rows.push_back('{ACT_FIND, 32'h0, 1, '{ST_DONE, 16'd15, 7'd2}});
        rows.push_back('{ACT_REMOVE, 32'hFFFFFFFF, 1, '{ST_DONE, 16'd0, 7'd1}});
        rows.push_back('{action_t'(3'd5), 32'h0, 1, '{ST_DONE, 16'd0, 7'd1}});
        rows.push_back('{action_t'(3'd7), 32'hA5A5A5A5, 1, '{ST_DONE, 16'd0, 7'd1}});
        rows.push_back('{ACT_INSERT, 32'h5A5A5A5A, 0, z});
        rows.push_back('{ACT_FIND, 32'h5A5A5A5A, 0, z});
        foreach (rows[i]) begin
            w.action = rows[i].act;
            w.neighbor_address = rows[i].addr;
            send_word(w, rows[i].known, rows[i].word);
        end

        // lifetime zero acts as one: insert then a single tick drops it
        write_lifetime(16'd0);
        w = '{ACT_INSERT, 32'h12345678}; send_word(w, 0, z);
        w = '{ACT_TICK, 32'h0}; send_word(w, 0, z);
        w = '{ACT_FIND, 32'h12345678}; send_word(w, 0, z);

        // fill to full, then overfill
        write_lifetime(16'd65535);
        for (int i = 0; i < DEPTH + 3; i++) begin
            w = '{ACT_INSERT, 32'h80000000 | i}; send_word(w, 0, z);
        end
        w = '{ACT_TICK, 32'h0}; send_word(w, 0, z);

        for (int ph = 0; ph < 6; ph++) begin
            write_lifetime(lifes[ph]);
            for (int n = 0; n < 170; n++) begin
                w.action = pick_act(ph == 1 ? 1 : 0);
                w.neighbor_address = pick_addr();
                send_word(w, 0, z);
                if (n == 80) begin
                    // hold off until the result side has drained
                    stop_input();
                    while (pending_words.size() != 0) @(posedge aclk);
                end
            end
        end
        stop_input();

        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DEPTH * 2 + 20) @(posedge aclk);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
